FILE: hw/rtl/fbc_pkg.sv
// Shared types and constants for the frustum box cull block.
package fbc_pkg;

   // Request commands
   localparam logic [1:0] CMD_LOAD_PROJ = 2'd0;
   localparam logic [1:0] CMD_LOAD_VIEW = 2'd1;
   localparam logic [1:0] CMD_TEST_BOX  = 2'd2;

   localparam int unsigned NUM_PLANES = 6;
   localparam logic [5:0]  ALL_PLANES = 6'h3F;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PLANES,
      ST_XFORM,
      ST_TEST,
      ST_DONE
   } state_type;

   // Multiply-accumulate control from sequencer to the shared unit
   typedef struct packed {
      logic       clear;   // start a new sum with this product
      logic       enable;  // add product this cycle
   } mac_ctrl_type;

endpackage

FILE: hw/rtl/fbc_mac.sv
// Shared signed multiply-accumulate unit: 33x33 product into a wide sum.
module fbc_mac
   import fbc_pkg::*;
(
   input  logic                clock,
   input  mac_ctrl_type        ctrl,
   input  logic signed [32:0]  op_a,
   input  logic signed [32:0]  op_b,
   output logic signed [71:0]  acc
);

   logic signed [65:0] prod_ff, prod_in;
   logic               add_ff, clr_ff;
   logic signed [71:0] acc_ff, acc_in;

   // Product register, then accumulate
   assign prod_in = op_a * op_b;

   always_comb begin
      acc_in = acc_ff;
      if (add_ff) begin
         if (clr_ff) acc_in = 72'(prod_ff);
         else acc_in = acc_ff + 72'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      add_ff  <= ctrl.enable;
      clr_ff  <= ctrl.clear;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

FILE: hw/rtl/frustum_box_cull.sv
// Frustum box cull: box tests on a single shared MAC, one request at a time.
// A projection load rebuilds 24 plane coefficients, one per cycle; a view load writes one element.
// A box test transforms 8 corners by 3 columns, then tests the 6 planes, each plane's corner loop
// ending early on a positive corner.
// Throughput: the next request is taken in the same cycle as the response is raised.
// Reset (synchronous, active high) clears matrices, planes and handshake state.
module frustum_box_cull
   import fbc_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command[1:0], element_index[5:2], element_value[37:6], center_x/y/z,
   // extent_x/y/z (32 bits each), zero pad to 232
   input  logic [231:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // visible[0], plane_mask[6:1], zero pad
   output logic [7:0]   rsp_tdata
);

   logic [1:0]         cmd;
   logic [3:0]         eidx;
   logic signed [31:0] evalue;
   assign cmd    = req_tdata[1:0];
   assign eidx   = req_tdata[5:2];
   assign evalue = req_tdata[37:6];

   logic signed [31:0] proj_ff [16];
   logic signed [31:0] view_ff [16];
   logic signed [32:0] plane_ff [24];
   logic signed [32:0] corner_ff [3];
   logic signed [32:0] ctr_ff [3], ext_ff [3];
   logic signed [31:0] tc_ff [8][3];

   state_type   st_ff, st_in;
   logic [4:0]  pidx_ff, pidx_in;    // plane coefficient rebuild index
   logic [2:0]  corner_idx_ff, corner_idx_in;
   logic [1:0]  col_ff, col_in;      // output column of the transform
   logic [2:0]  plane_idx_ff, plane_idx_in;
   logic [2:0]  term_ff, term_in;    // 0..3 issue, 4..5 drain
   logic [5:0]  mask_ff, mask_in;
   logic        rsp_v_ff, rsp_v_in;
   logic [7:0]  rsp_d_ff, rsp_d_in;

   mac_ctrl_type       ctrl;
   logic signed [32:0] op_a, op_b;
   logic signed [71:0] acc;

   fbc_mac u_mac (.clock(clock), .ctrl(ctrl), .op_a(op_a), .op_b(op_b), .acc(acc));

   // Saturating conversion of the transform sum
   logic signed [71:0] shifted;
   logic signed [31:0] sat;
   assign shifted = acc >>> FRAC_BITS;
   always_comb begin
      if (shifted > 72'sd2147483647) sat = 32'sh7FFFFFFF;
      else if (shifted < -72'sd2147483648) sat = 32'sh80000000;
      else sat = shifted[31:0];
   end

   // Plane rebuild coefficient for index pidx: plane = pidx/4, row = pidx%4
   logic [2:0]         rb_plane;
   logic [1:0]         rb_row;
   logic signed [32:0] rb_base, rb_other, rb_val;
   assign rb_plane = 3'(pidx_ff >> 2);
   assign rb_row   = pidx_ff[1:0];
   always_comb begin
      rb_base  = 33'(proj_ff[{rb_row, 2'd3}]);
      rb_other = 33'(proj_ff[{rb_row, 2'(rb_plane >> 1)}]);
      case (rb_plane)
         3'd0, 3'd3, 3'd4: rb_val = rb_base - rb_other;
         default:          rb_val = rb_base + rb_other;
      endcase
   end

   // Operand selection for the MAC
   logic signed [32:0] one_q;
   assign one_q = 33'sd1 <<< FRAC_BITS;
   always_comb begin
      op_a = '0;
      op_b = '0;
      if (st_ff == ST_XFORM) begin
         if (term_ff == 3'd3) begin
            op_a = 33'(view_ff[{2'd3, col_ff}]);
            op_b = one_q;
         end else if (term_ff < 3'd3) begin
            op_a = corner_ff[term_ff[1:0]];
            op_b = 33'(view_ff[{term_ff[1:0], col_ff}]);
         end
      end else begin
         if (term_ff == 3'd3) begin
            op_a = plane_ff[5'({plane_idx_ff, 2'd3})];
            op_b = one_q;
         end else if (term_ff < 3'd3) begin
            op_a = plane_ff[5'({plane_idx_ff, term_ff[1:0]})];
            op_b = 33'(tc_ff[corner_idx_ff][term_ff[1:0]]);
         end
      end
   end

   // Sequencer
   always_comb begin
      st_in         = st_ff;
      pidx_in       = pidx_ff;
      corner_idx_in = corner_idx_ff;
      col_in        = col_ff;
      plane_idx_in  = plane_idx_ff;
      term_in       = term_ff;
      mask_in       = mask_ff;
      rsp_v_in      = rsp_v_ff;
      rsp_d_in      = rsp_d_ff;
      ctrl.enable   = 1'b0;
      ctrl.clear    = 1'b0;
      req_tready    = 1'b0;
      if (rsp_v_ff && rsp_tready) rsp_v_in = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (cmd)
                  CMD_LOAD_PROJ: begin
                     st_in = ST_PLANES;
                     pidx_in = '0;
                  end
                  CMD_TEST_BOX: begin
                     st_in = ST_XFORM;
                     corner_idx_in = '0;
                     col_in = '0;
                     term_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_PLANES: begin
            pidx_in = pidx_ff + 5'd1;
            if (pidx_ff == 5'd23) st_in = ST_IDLE;
         end
         ST_XFORM: begin
            ctrl.enable = term_ff < 3'd4;
            ctrl.clear  = term_ff == 3'd0;
            term_in = term_ff + 3'd1;
            if (term_ff == 3'd5) begin
               term_in = '0;
               if (col_ff == 2'd2) begin
                  col_in = '0;
                  if (corner_idx_ff == 3'd7) begin
                     st_in = ST_TEST;
                     plane_idx_in = '0;
                     corner_idx_in = '0;
                     mask_in = '0;
                  end else corner_idx_in = corner_idx_ff + 3'd1;
               end else col_in = col_ff + 2'd1;
            end
         end
         ST_TEST: begin
            ctrl.enable = term_ff < 3'd4;
            ctrl.clear  = term_ff == 3'd0;
            term_in = term_ff + 3'd1;
            if (term_ff == 3'd5) begin
               term_in = '0;
               if (acc > 72'sd0 || corner_idx_ff == 3'd7) begin
                  if (acc > 72'sd0) mask_in[plane_idx_ff] = 1'b1;
                  corner_idx_in = '0;
                  if (plane_idx_ff == 3'd5) st_in = ST_DONE;
                  else plane_idx_in = plane_idx_ff + 3'd1;
               end else corner_idx_in = corner_idx_ff + 3'd1;
            end
         end
         ST_DONE: begin
            if (!rsp_v_ff) begin
               rsp_v_in = 1'b1;
               rsp_d_in = {1'b0, mask_ff, mask_ff == ALL_PLANES};
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         rsp_v_ff <= 1'b0;
         pidx_ff  <= '0;
         term_ff  <= '0;
      end else begin
         st_ff    <= st_in;
         rsp_v_ff <= rsp_v_in;
         pidx_ff  <= pidx_in;
         term_ff  <= term_in;
      end
   end

   // Stores; reset clears the matrices and planes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            proj_ff[i] <= '0;
            view_ff[i] <= '0;
         end
         for (int i = 0; i < 24; i++) plane_ff[i] <= '0;
      end else begin
         if (st_ff == ST_IDLE && req_tvalid && cmd == CMD_LOAD_PROJ) proj_ff[eidx] <= evalue;
         if (st_ff == ST_IDLE && req_tvalid && cmd == CMD_LOAD_VIEW) view_ff[eidx] <= evalue;
         if (st_ff == ST_PLANES) plane_ff[pidx_ff] <= rb_val;
      end
   end

   // Payload registers; the first corner is built straight from the request
   always_ff @(posedge clock) begin
      corner_idx_ff <= corner_idx_in;
      col_ff        <= col_in;
      plane_idx_ff  <= plane_idx_in;
      mask_ff       <= mask_in;
      rsp_d_ff      <= rsp_d_in;
      if (st_ff == ST_IDLE && req_tvalid && cmd == CMD_TEST_BOX) begin
         for (int c = 0; c < 3; c++) begin
            ctr_ff[c]    <= 33'(signed'(req_tdata[38 + 32*c +: 32]));
            ext_ff[c]    <= 33'(signed'(req_tdata[134 + 32*c +: 32]));
            corner_ff[c] <= 33'(signed'(req_tdata[38 + 32*c +: 32]))
                          + 33'(signed'(req_tdata[134 + 32*c +: 32]));
         end
      end else begin
         for (int c = 0; c < 3; c++)
            corner_ff[c] <= corner_idx_in[c] ? ctr_ff[c] - ext_ff[c] : ctr_ff[c] + ext_ff[c];
      end
      if (st_ff == ST_XFORM && term_ff == 3'd5) tc_ff[corner_idx_ff][col_ff] <= sat;
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;

endmodule

FILE: hw/rtl/fbc_checker.sv
// Port-level checks for the frustum box cull block, bound to the top level.
module fbc_checker
   import fbc_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [1:0]   req_cmd,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [7:0]   rsp_tdata
);

   // visible agrees with a full mask
   a_vis: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[6:1] == ALL_PLANES)))
      else $error("visible disagrees with mask");

   // pad bit stays zero
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[7]) else $error("pad bit set");

   // stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped");

   // accepting a box or projection request closes the input on the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_cmd == CMD_TEST_BOX || req_cmd == CMD_LOAD_PROJ)
      |=> !req_tready)
      else $error("input open while busy");

endmodule

bind frustum_box_cull fbc_checker u_fbc_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready), .req_cmd(req_tdata[1:0]),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
